>>> src/apsc_pkg.sv
// shared types and constants of the step counter
package apsc_pkg;

	localparam int AccelW = 16;
	localparam int TimeW = 32;
	localparam int ThreshW = 15;
	localparam int GapW = 16;
	localparam int CfgDataW = 16;
	localparam int SquareW = 31;
	localparam int MagW = 33;
	localparam int ThreshSqW = 2 * ThreshW;
	localparam int StepsW = 24;

	localparam logic [ThreshW-1:0] StepThresholdReset = 15'd3328;
	localparam logic [GapW-1:0] MinStepGapReset = 16'd200;
	localparam logic [StepsW-1:0] StepsMax = {StepsW{1'b1}};

	localparam int MidDepthDefault = 4;
	localparam int OutDepthDefault = 4;

	typedef enum logic [0:0] {
		CfgStepThreshold = 1'b0,
		CfgMinStepGap = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [MagW-1:0] mag_sq;
		logic [TimeW-1:0] time_ms;
		logic clear_count;
	} mid_item_t;

	typedef struct packed {
		logic [StepsW-1:0] steps;
		logic step_seen;
	} result_t;

	typedef struct packed {
		logic we;
		cfg_reg_t index;
		logic [CfgDataW-1:0] data;
	} cfg_write_t;

endpackage

>>> src/accel_peak_step_counter.sv
// top level of the threshold-and-peak step counter
// a sample passes two front stages (squares, sum) and the middle queue into
//   the result queue, then empty goes low; throughput: one sample per cycle
//   while the queues have room; the back end judges and registers the count
// reset: arst_n clears the count, dead zone, history and both queues at once and
//   loads the threshold and gap registers with their reset values; no clearing pass
module accel_peak_step_counter #(
	parameter int MidDepth = apsc_pkg::MidDepthDefault,
	parameter int OutDepth = apsc_pkg::OutDepthDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample side
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [apsc_pkg::AccelW-1:0]   accel_x,
	input  logic signed [apsc_pkg::AccelW-1:0]   accel_y,
	input  logic signed [apsc_pkg::AccelW-1:0]   accel_z,
	input  logic        [apsc_pkg::TimeW-1:0]    time_ms,
	input  logic                                 clear_count,
	// result side
	output logic                                 empty,
	input  logic                                 pop,
	output logic        [apsc_pkg::StepsW-1:0]   steps,
	output logic                                 step_seen,
	// register write port
	input  logic                                 cfg_we,
	input  apsc_pkg::cfg_reg_t                   cfg_index,
	input  logic        [apsc_pkg::CfgDataW-1:0] cfg_data
);
	import apsc_pkg::*;

	// front to back queue
	logic front_valid;
	mid_item_t front_item;
	logic mid_full;
	logic mid_empty;
	logic mid_pop;
	logic [$bits(mid_item_t)-1:0] mid_rdata;
	mid_item_t mid_item;

	// back to result queue
	logic out_full;
	logic res_push;
	result_t res;
	logic [$bits(result_t)-1:0] out_rdata;
	result_t out_res;

	cfg_write_t cfg;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	// squares then sum; stalls only when the middle queue is full
	apsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.time_ms     (time_ms),
		.clear_count (clear_count),
		.item_valid  (front_valid),
		.item        (front_item),
		.item_ready  (!mid_full)
	);

	// short queue so the front keeps taking samples while the back waits on pop
	apsc_fifo #(
		.Width ($bits(mid_item_t)),
		.Depth (MidDepth)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.wdata  (front_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_item = mid_item_t'(mid_rdata);

	// dead zone, peak, gap and saturating count; one item per cycle unless out_full
	apsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_empty (mid_empty),
		.mid_item  (mid_item),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue; its head drives the result ports directly
	apsc_fifo #(
		.Width ($bits(result_t)),
		.Depth (OutDepth)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign out_res = result_t'(out_rdata);
	assign steps = out_res.steps;
	assign step_seen = out_res.step_seen;

endmodule

>>> src/apsc_fifo.sv
// small register queue with push/full and pop/empty sides
module apsc_fifo #(
	parameter int Width = 1,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AddrW-1:0] wr_ptr_q;
	logic [AddrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> src/apsc_front.sv
// front end: takes samples and works out the squared magnitude in two stages
module apsc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [apsc_pkg::AccelW-1:0]   accel_x,
	input  logic signed [apsc_pkg::AccelW-1:0]   accel_y,
	input  logic signed [apsc_pkg::AccelW-1:0]   accel_z,
	input  logic        [apsc_pkg::TimeW-1:0]    time_ms,
	input  logic                                 clear_count,
	output logic                                 item_valid,
	output apsc_pkg::mid_item_t                  item,
	input  logic                                 item_ready
);
	import apsc_pkg::*;

	logic signed [2*AccelW-1:0] prod_x;
	logic signed [2*AccelW-1:0] prod_y;
	logic signed [2*AccelW-1:0] prod_z;

	logic valid_s1;
	logic [SquareW-1:0] sq_x_s1;
	logic [SquareW-1:0] sq_y_s1;
	logic [SquareW-1:0] sq_z_s1;
	logic [TimeW-1:0] time_s1;
	logic clear_s1;

	logic valid_s2;
	logic [MagW-1:0] mag_s2;
	logic [TimeW-1:0] time_s2;
	logic clear_s2;

	logic ready_s1;
	logic ready_s2;
	logic take;

	// each square of a 16-bit value is at most 2^30
	assign prod_x = accel_x * accel_x;
	assign prod_y = accel_y * accel_y;
	assign prod_z = accel_z * accel_z;

	assign ready_s2 = !valid_s2 || item_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full = !ready_s1;
	assign take = push && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= push;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_x_s1 <= prod_x[SquareW-1:0];
			sq_y_s1 <= prod_y[SquareW-1:0];
			sq_z_s1 <= prod_z[SquareW-1:0];
			time_s1 <= time_ms;
			clear_s1 <= clear_count;
		end
		if (ready_s2 && valid_s1) begin
			mag_s2 <= MagW'(sq_x_s1) + MagW'(sq_y_s1) + MagW'(sq_z_s1);
			time_s2 <= time_s1;
			clear_s2 <= clear_s1;
		end
	end

	assign item_valid = valid_s2;
	assign item.mag_sq = mag_s2;
	assign item.time_ms = time_s2;
	assign item.clear_count = clear_s2;

endmodule

>>> src/apsc_back.sv
// back end: judges each magnitude against the step rules and keeps the count
module apsc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  apsc_pkg::cfg_write_t    cfg,
	input  logic                    mid_empty,
	input  apsc_pkg::mid_item_t     mid_item,
	output logic                    mid_pop,
	input  logic                    out_full,
	output logic                    res_push,
	output apsc_pkg::result_t       res
);
	import apsc_pkg::*;

	logic [ThreshW-1:0] thr_q;
	logic [GapW-1:0] gap_cfg_q;
	logic [ThreshSqW-1:0] thr_sq_q;
	logic [ThreshSqW-1:0] thr_wide;

	logic [MagW-1:0] prev_q;
	logic dead_q;
	logic [TimeW-1:0] last_q;
	logic any_q;
	logic [StepsW-1:0] total_q;

	logic [StepsW-1:0] base_total;
	logic [MagW-1:0] thr_sq_ext;
	logic above;
	logic below;
	logic rising;
	logic [TimeW-1:0] gap;
	logic gap_ok;
	logic hit;
	logic [StepsW-1:0] new_total;

	// config registers; the threshold square is registered from the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= StepThresholdReset;
			gap_cfg_q <= MinStepGapReset;
		end else if (cfg.we) begin
			unique case (cfg.index)
				CfgStepThreshold: thr_q <= cfg.data[ThreshW-1:0];
				CfgMinStepGap:    gap_cfg_q <= cfg.data[GapW-1:0];
				default:          thr_q <= thr_q;
			endcase
		end
	end

	assign thr_wide = ThreshSqW'(thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= ThreshSqW'(StepThresholdReset) * ThreshSqW'(StepThresholdReset);
		end else begin
			thr_sq_q <= thr_wide * thr_wide;
		end
	end

	assign mid_pop = !mid_empty && !out_full;
	assign res_push = mid_pop;

	assign base_total = mid_item.clear_count ? '0 : total_q;
	assign thr_sq_ext = MagW'(thr_sq_q);
	assign above = mid_item.mag_sq > thr_sq_ext;
	assign below = mid_item.mag_sq < thr_sq_ext;
	assign rising = mid_item.mag_sq > prev_q;
	assign gap = mid_item.time_ms - last_q;
	assign gap_ok = !any_q || (gap > TimeW'(gap_cfg_q));
	assign hit = !dead_q && above && rising && gap_ok;
	assign new_total = (hit && base_total != StepsMax) ? base_total + 1'b1 : base_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			dead_q <= 1'b0;
			last_q <= '0;
			any_q <= 1'b0;
			total_q <= '0;
		end else if (mid_pop) begin
			prev_q <= mid_item.mag_sq;
			total_q <= new_total;
			if (hit) begin
				last_q <= mid_item.time_ms;
				any_q <= 1'b1;
			end
			// a hit is always above threshold, so the two never clash
			if (below) begin
				dead_q <= 1'b0;
			end else if (hit) begin
				dead_q <= 1'b1;
			end
		end
	end

	assign res.steps = new_total;
	assign res.step_seen = hit;

	a_hit_enters_dead_zone: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop && hit |=> dead_q && any_q)
		else $error("counted step did not enter dead zone");

	a_count_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!mid_pop |=> $stable(total_q) && $stable(dead_q) && $stable(last_q))
		else $error("step state changed without a transaction");

	a_count_holds_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop && !hit && !mid_item.clear_count |=> $stable(total_q) && $stable(last_q))
		else $error("step count moved without a counted step");

	a_seen_means_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.step_seen |-> res.steps != '0)
		else $error("step seen with zero count");

endmodule
